@@ rtl/core/sfd_pkg.sv @@
// Shared constants for the serial frame deframer and checker.
package sfd_pkg;

    // Result error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_RECEIVER  = 3'd2;
    localparam logic [2:0] ERR_VERSION   = 3'd3;
    localparam logic [2:0] ERR_LENGTH    = 3'd4;
    localparam logic [2:0] ERR_CHECK     = 3'd5;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    // Framing
    localparam logic [7:0] ADDR_MAX      = 8'd127;
    localparam logic [7:0] V0_LEN        = 8'd7;
    localparam logic [7:0] V1_LEN        = 8'd9;
    localparam logic [7:0] MIN_LEN       = 8'd4;
    localparam logic [6:0] VER_PARITY    = 7'd0;
    localparam logic [6:0] VER_CRC       = 7'd1;

    // Commands whose value carries hundredths in the low byte
    localparam logic [7:0] CMD_HUMID     = 8'h68;  // 'h'
    localparam logic [7:0] CMD_TEMP      = 8'h74;  // 't'
    localparam logic [7:0] CMD_SET       = 8'h73;  // 's'

endpackage

@@ rtl/core/sfd_crc_step.sv @@
// One-byte update of a CRC-16/CCITT-FALSE accumulator, MSB first.
module sfd_crc_step (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import sfd_pkg::*;

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

@@ rtl/core/serial_frame_deframer_checker_top.sv @@
// Top level: byte-stream deframer with parity / CRC-16 frame check.
// Pipeline: a word in the input register is processed once the result slot is free;
//   its result, if any, goes to o_valid (two register stages: input, result).
// Throughput: one byte per cycle; o_stall rises only while a result is held by i_stall.
// Reset: synchronous, active low; hunts for a start byte, accumulators at init values.
// The parity and 8-step CRC byte update lie between the two registers.
module serial_frame_deframer_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_error_code,
    output logic [6:0]  o_sender_address,
    output logic [7:0]  o_receiver_address,
    output logic        o_reply_flag,
    output logic [6:0]  o_frame_version,
    output logic [7:0]  o_command_char,
    output logic [15:0] o_value_word,
    output logic        o_decimal_value,
    output logic [15:0] o_received_check,
    output logic [7:0]  o_frame_length
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FRAME,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [6:0]  sender;
        logic [7:0]  receiver;
        logic        reply;
        logic [6:0]  version;
        logic [7:0]  command;
        logic [15:0] value;
        logic        decimal;
        logic [15:0] check;
        logic [7:0]  length;
    } t_result;

    // ---------------- input register ----------------
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // ---------------- frame state ----------------
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_skip, n_skip;
    logic [6:0]  r_sender, n_sender;
    logic [7:0]  r_receiver, n_receiver;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_value, n_value;
    logic [7:0]  r_parity, n_parity;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_low, n_crc_low;

    // ---------------- result register ----------------
    logic        r_out_valid;
    t_result     r_out;

    // Step logic outputs
    logic        res_valid;
    t_result     res;
    logic [15:0] crc_seed, crc_next;
    logic        advance;

    // The stage moves whenever the result slot is free or being emptied.
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;

    // CRC seed is the init value on a start byte, else the running sum.
    assign crc_seed = (r_phase == PH_HUNT) ? CRC_INIT : r_crc;

    sfd_crc_step u_crc (
        .i_crc  (crc_seed),
        .i_byte (r_in_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        logic [7:0]  b;
        logic [6:0]  ver;
        logic [7:0]  pos;
        logic [15:0] rx;
        b   = r_in_byte;
        ver = r_flags[7:1];
        pos = r_pos;
        rx  = {b, r_crc_low};

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_sender   = r_sender;
        n_receiver = r_receiver;
        n_flags    = r_flags;
        n_length   = r_length;
        n_command  = r_command;
        n_value    = r_value;
        n_parity   = r_parity;
        n_crc      = r_crc;
        n_crc_low  = r_crc_low;
        res_valid  = 1'b0;
        res        = '0;

        case (r_phase)
            PH_SKIP: begin
                if (r_skip != 8'd0) begin
                    n_skip = r_skip - 8'd1;
                end
                if (n_skip == 8'd0) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_HUNT: begin
                // start byte: anything but noise (zero or above 127)
                if (b != 8'd0 && b <= ADDR_MAX) begin
                    n_phase    = PH_FRAME;
                    n_pos      = 8'd1;
                    n_sender   = b[6:0];
                    n_receiver = '0;
                    n_flags    = '0;
                    n_length   = '0;
                    n_command  = '0;
                    n_value    = '0;
                    n_crc_low  = '0;
                    n_parity   = b;
                    n_crc      = crc_next;
                end
            end
            PH_FRAME: begin
                if (r_pos != 8'hFF) begin
                    pos = r_pos + 8'd1;
                end
                n_pos = pos;
                if (pos == 8'd2) begin
                    n_receiver = b;
                end else if (pos == 8'd3) begin
                    n_flags = b;
                    ver     = b[7:1];
                    if (ver != VER_CRC) begin
                        if (r_receiver > ADDR_MAX) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_RECEIVER;
                            n_skip         = V0_LEN - pos;
                            n_phase        = PH_SKIP;
                        end else if (ver != VER_PARITY) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_VERSION;
                            n_skip         = V0_LEN - pos;
                            n_phase        = PH_SKIP;
                        end
                    end
                end else if (ver == VER_PARITY) begin
                    if (pos == 8'd4) begin
                        n_command = b;
                    end else if (pos == 8'd5) begin
                        n_value = {b, 8'h00};
                    end else if (pos == 8'd6) begin
                        n_value = {r_value[15:8], b};
                    end else begin
                        res_valid = 1'b1;
                        n_phase   = PH_HUNT;
                        if (b == r_parity) begin
                            res.error_code = ERR_OK;
                            res.sender     = r_sender;
                            res.receiver   = r_receiver;
                            res.reply      = r_flags[0];
                            res.version    = r_flags[7:1];
                            res.command    = r_command;
                            res.value      = r_value;
                            res.decimal    = (r_command inside {CMD_HUMID, CMD_TEMP, CMD_SET});
                            res.check      = {8'h00, b};
                            res.length     = V0_LEN;
                        end else begin
                            res.error_code = ERR_CHECK;
                        end
                    end
                end else begin
                    if (pos == 8'd4) begin
                        n_length = b;
                        if (r_receiver > ADDR_MAX) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_RECEIVER;
                            if (b > pos) begin
                                n_skip  = b - pos;
                                n_phase = PH_SKIP;
                            end else begin
                                n_skip  = 8'd0;
                                n_phase = PH_HUNT;
                            end
                        end else if (b <= MIN_LEN) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_LENGTH;
                            n_phase        = PH_HUNT;
                        end
                    end else if (r_length != V1_LEN) begin
                        // wrong length: report once the declared length is reached
                        if (pos >= r_length) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_LENGTH;
                            n_phase        = PH_HUNT;
                        end
                    end else if (pos == 8'd5) begin
                        n_command = b;
                    end else if (pos == 8'd6) begin
                        n_value = {b, 8'h00};
                    end else if (pos == 8'd7) begin
                        n_value = {r_value[15:8], b};
                    end else if (pos == 8'd8) begin
                        n_crc_low = b;
                    end else begin
                        res_valid = 1'b1;
                        n_phase   = PH_HUNT;
                        if (rx == r_crc) begin
                            res.error_code = ERR_OK;
                            res.sender     = r_sender;
                            res.receiver   = r_receiver;
                            res.reply      = r_flags[0];
                            res.version    = r_flags[7:1];
                            res.command    = r_command;
                            res.value      = r_value;
                            res.decimal    = (r_command inside {CMD_HUMID, CMD_TEMP, CMD_SET});
                            res.check      = rx;
                            res.length     = V1_LEN;
                        end else begin
                            res.error_code = ERR_CHECK;
                        end
                    end
                end
                // accumulators cover the bytes ahead of the check field
                if (pos <= 8'd6) begin
                    n_parity = r_parity ^ b;
                end
                if (pos <= 8'd7) begin
                    n_crc = crc_next;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // Last byte of a buffer closes any open frame.
        if (r_in_last) begin
            if (!res_valid && n_phase == PH_FRAME) begin
                res_valid      = 1'b1;
                res            = '0;
                res.error_code = ERR_SHORT;
            end
            n_phase = PH_HUNT;
            n_skip  = 8'd0;
            n_pos   = 8'd0;
        end else if (n_phase == PH_HUNT) begin
            n_pos = 8'd0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_buffer;
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_pos      <= '0;
            r_skip     <= '0;
            r_sender   <= '0;
            r_receiver <= '0;
            r_flags    <= '0;
            r_length   <= '0;
            r_command  <= '0;
            r_value    <= '0;
            r_parity   <= '0;
            r_crc      <= CRC_INIT;
            r_crc_low  <= '0;
        end else if (r_in_valid && advance) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_skip     <= n_skip;
            r_sender   <= n_sender;
            r_receiver <= n_receiver;
            r_flags    <= n_flags;
            r_length   <= n_length;
            r_command  <= n_command;
            r_value    <= n_value;
            r_parity   <= n_parity;
            r_crc      <= n_crc;
            r_crc_low  <= n_crc_low;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
        if (advance && r_in_valid && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_error_code       = r_out.error_code;
    assign o_sender_address   = r_out.sender;
    assign o_receiver_address = r_out.receiver;
    assign o_reply_flag       = r_out.reply;
    assign o_frame_version    = r_out.version;
    assign o_command_char     = r_out.command;
    assign o_value_word       = r_out.value;
    assign o_decimal_value    = r_out.decimal;
    assign o_received_check   = r_out.check;
    assign o_frame_length     = r_out.length;

endmodule

@@ rtl/core/sfd_checker.sv @@
// Port-level checks for the deframer, bound to its top level.
module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_error_code,
    input logic [6:0]  o_sender_address,
    input logic [7:0]  o_receiver_address,
    input logic        o_reply_flag,
    input logic [6:0]  o_frame_version,
    input logic [7:0]  o_command_char,
    input logic [15:0] o_value_word,
    input logic        o_decimal_value,
    input logic [15:0] o_received_check,
    input logic [7:0]  o_frame_length
);
    import sfd_pkg::*;

    // held result stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_error_code))
        else $error("result dropped while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_error_code <= ERR_CHECK)
        else $error("bad error code");

    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |->
            o_sender_address == 7'd0 && o_receiver_address == 8'd0 &&
            !o_reply_flag && o_frame_version == 7'd0 && o_command_char == 8'd0 &&
            o_value_word == 16'd0 && !o_decimal_value &&
            o_received_check == 16'd0 && o_frame_length == 8'd0)
        else $error("error result carries fields");

    a_ok_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == ERR_OK |->
            o_sender_address != 7'd0 && o_receiver_address <= ADDR_MAX &&
            ((o_frame_length == V0_LEN && o_frame_version == VER_PARITY &&
              o_received_check[15:8] == 8'd0) ||
             (o_frame_length == V1_LEN && o_frame_version == VER_CRC)))
        else $error("good frame with inconsistent version or length");

endmodule

bind serial_frame_deframer_checker_top sfd_checker u_sfd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_error_code       (o_error_code),
    .o_sender_address   (o_sender_address),
    .o_receiver_address (o_receiver_address),
    .o_reply_flag       (o_reply_flag),
    .o_frame_version    (o_frame_version),
    .o_command_char     (o_command_char),
    .o_value_word       (o_value_word),
    .o_decimal_value    (o_decimal_value),
    .o_received_check   (o_received_check),
    .o_frame_length     (o_frame_length)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the serial frame deframer: byte stream in, one checked result per frame.
module testbench;
    import sfd_pkg::*;

    // Cycles with no word moving on either channel before the run is declared hung.
    // The worst case is the long receiver hold-off below plus a few stall streaks.
    localparam int QUIET_LIMIT   = 4000;
    // Settle time after the last result: two register stages, plus margin.
    localparam int DRAIN_CYCLES  = 8;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 300;
    // Random words per random phase, at least.
    localparam int PHASE_WORDS   = 300;
    localparam int N_DIRECTED    = 30;

    // One result word as the block presents it.
    typedef struct packed {
        logic [2:0]  code;
        logic [6:0]  sender;
        logic [7:0]  receiver;
        logic        reply;
        logic [6:0]  version;
        logic [7:0]  command;
        logic [15:0] value;
        logic        decimal;
        logic [15:0] check;
        logic [7:0]  length;
    } t_frame_result;

    // Scanner state of the predictor.
    typedef enum logic [1:0] {HUNTING, IN_FRAME, SKIPPING} t_scan_state;

    // One directed stimulus word; 'typed' rows carry an error code known by inspection.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] code;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_buffer;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_error_code;
    logic [6:0]  o_sender_address;
    logic [7:0]  o_receiver_address;
    logic        o_reply_flag;
    logic [6:0]  o_frame_version;
    logic [7:0]  o_command_char;
    logic [15:0] o_value_word;
    logic        o_decimal_value;
    logic [15:0] o_received_check;
    logic [7:0]  o_frame_length;

    serial_frame_deframer_checker_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_end_of_buffer    (i_end_of_buffer),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_error_code       (o_error_code),
        .o_sender_address   (o_sender_address),
        .o_receiver_address (o_receiver_address),
        .o_reply_flag       (o_reply_flag),
        .o_frame_version    (o_frame_version),
        .o_command_char     (o_command_char),
        .o_value_word       (o_value_word),
        .o_decimal_value    (o_decimal_value),
        .o_received_check   (o_received_check),
        .o_frame_length     (o_frame_length)
    );

    // Results still owed by the block, oldest first.
    t_frame_result pending_frames[$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            words_sent     = 0;
    int            sender_idle_pct = 0;
    int            stall_pct       = 0;
    int            long_hold_left  = 0;

    // Tags riding along with the word on the input channel (directed rows only).
    logic          row_typed;
    logic [2:0]    row_code;

    // Predictor copy of the scanner state.
    t_scan_state   scan_state;
    logic [7:0]    frame_pos;
    logic [7:0]    skip_left;
    logic [6:0]    cur_sender;
    logic [7:0]    cur_receiver;
    logic [7:0]    cur_flags;
    logic [7:0]    cur_length;
    logic [7:0]    cur_command;
    logic [15:0]   cur_value;
    logic [7:0]    parity_sum;
    logic [15:0]   crc_sum;
    logic [7:0]    crc_low_byte;

    // Directed words. Noise at both ends of the byte range, a clean parity frame with a decimal
    // command, then a case per error path but ERR_CHECK. End of buffer cuts pending skips short.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b0, ERR_OK},       // noise: zero
        '{8'hFF, 1'b0, 1'b0, ERR_OK},       // noise: top of range
        '{8'h7F, 1'b0, 1'b0, ERR_OK},       // v0 frame, highest sender
        '{8'h00, 1'b0, 1'b0, ERR_OK},       //   receiver 0
        '{8'h00, 1'b0, 1'b0, ERR_OK},       //   flags: v0, no reply
        '{8'h74, 1'b0, 1'b0, ERR_OK},       //   't' -> decimal value
        '{8'hFF, 1'b0, 1'b0, ERR_OK},       //   value high
        '{8'h00, 1'b0, 1'b0, ERR_OK},       //   value low
        '{8'hF4, 1'b0, 1'b0, ERR_OK},       //   parity of the six bytes above
        '{8'h01, 1'b0, 1'b0, ERR_OK},       // receiver above 127, caught on flags
        '{8'h80, 1'b0, 1'b0, ERR_OK},
        '{8'h00, 1'b1, 1'b1, ERR_RECEIVER},
        '{8'h02, 1'b0, 1'b0, ERR_OK},       // highest version, unsupported
        '{8'h03, 1'b0, 1'b0, ERR_OK},
        '{8'hFE, 1'b1, 1'b1, ERR_VERSION},
        '{8'h01, 1'b0, 1'b0, ERR_OK},       // v1 with length 0: hunt resumes at once
        '{8'h02, 1'b0, 1'b0, ERR_OK},
        '{8'h03, 1'b0, 1'b0, ERR_OK},
        '{8'h00, 1'b0, 1'b1, ERR_LENGTH},
        '{8'h01, 1'b0, 1'b0, ERR_OK},       // v1 receiver above 127, caught on length
        '{8'h80, 1'b0, 1'b0, ERR_OK},
        '{8'h02, 1'b0, 1'b0, ERR_OK},
        '{8'h09, 1'b1, 1'b1, ERR_RECEIVER},
        '{8'h01, 1'b0, 1'b0, ERR_OK},       // v1 length 5: error on the fifth byte
        '{8'h02, 1'b0, 1'b0, ERR_OK},
        '{8'h02, 1'b0, 1'b0, ERR_OK},
        '{8'h05, 1'b0, 1'b0, ERR_OK},
        '{8'h33, 1'b0, 1'b1, ERR_LENGTH},
        '{8'h05, 1'b0, 1'b0, ERR_OK},       // frame cut by end of buffer
        '{8'h06, 1'b1, 1'b1, ERR_SHORT}
    };

    int sender_idle_by_phase [4] = '{0, 64, 0, 33};
    int stall_by_phase       [4] = '{0, 0, 64, 33};

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++)
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        return c;
    endfunction

    function automatic t_frame_result error_result(input logic [2:0] code);
        t_frame_result r;
        r      = '0;
        r.code = code;
        return r;
    endfunction

    function automatic t_frame_result ok_result(input logic [15:0] chk, input logic [7:0] len);
        t_frame_result r;
        r.code     = ERR_OK;
        r.sender   = cur_sender;
        r.receiver = cur_receiver;
        r.reply    = cur_flags[0];
        r.version  = cur_flags[7:1];
        r.command  = cur_command;
        r.value    = cur_value;
        r.decimal  = (cur_command == CMD_HUMID || cur_command == CMD_TEMP ||
                      cur_command == CMD_SET);
        r.check    = chk;
        r.length   = len;
        return r;
    endfunction

    // Append one owed result at the tail of the queue.
    function automatic void queue_result(input t_frame_result r);
        pending_frames = {pending_frames, r};
    endfunction

    // After an error, drop whatever is left of the declared frame.
    task automatic drop_rest(input logic [7:0] len);
        if (len > frame_pos) begin
            skip_left  = len - frame_pos;
            scan_state = SKIPPING;
        end else begin
            skip_left  = 8'd0;
            scan_state = HUNTING;
        end
    endtask

    task automatic reset_scanner();
        scan_state   = HUNTING;
        frame_pos    = '0;
        skip_left    = '0;
        cur_sender   = '0;
        cur_receiver = '0;
        cur_flags    = '0;
        cur_length   = '0;
        cur_command  = '0;
        cur_value    = '0;
        parity_sum   = '0;
        crc_sum      = CRC_INIT;
        crc_low_byte = '0;
    endtask

    // Advance the scanner by one received byte; 'got' tells whether a result is due.
    task automatic deframe_byte(input logic [7:0] b, input logic last,
                                output logic got, output t_frame_result r);
        logic [6:0]  ver;
        logic [15:0] rx;
        got = 1'b0;
        r   = '0;
        case (scan_state)
            SKIPPING: begin
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    scan_state = HUNTING;
            end
            HUNTING: begin
                if (b != 8'd0 && b <= ADDR_MAX) begin
                    scan_state   = IN_FRAME;
                    frame_pos    = 8'd1;
                    cur_sender   = b[6:0];
                    cur_receiver = '0;
                    cur_flags    = '0;
                    cur_length   = '0;
                    cur_command  = '0;
                    cur_value    = '0;
                    crc_low_byte = '0;
                    parity_sum   = b;
                    crc_sum      = crc16_ccitt(CRC_INIT, b);
                end
            end
            default: begin
                if (frame_pos < 8'd255)
                    frame_pos++;
                ver = cur_flags[7:1];
                if (frame_pos == 8'd2) begin
                    cur_receiver = b;
                end else if (frame_pos == 8'd3) begin
                    cur_flags = b;
                    ver       = b[7:1];
                    if (ver != VER_CRC) begin
                        // v1 defers the receiver check to the length byte
                        if (cur_receiver > ADDR_MAX) begin
                            r   = error_result(ERR_RECEIVER);
                            got = 1'b1;
                            drop_rest(V0_LEN);
                        end else if (ver != VER_PARITY) begin
                            r   = error_result(ERR_VERSION);
                            got = 1'b1;
                            drop_rest(V0_LEN);
                        end
                    end
                end else if (ver == VER_PARITY) begin
                    case (frame_pos)
                        8'd4: cur_command = b;
                        8'd5: cur_value = {b, 8'h00};
                        8'd6: cur_value[7:0] = b;
                        default: begin
                            r          = (b == parity_sum) ? ok_result({8'h00, b}, V0_LEN)
                                                           : error_result(ERR_CHECK);
                            got        = 1'b1;
                            scan_state = HUNTING;
                        end
                    endcase
                end else if (frame_pos == 8'd4) begin
                    cur_length = b;
                    if (cur_receiver > ADDR_MAX) begin
                        r   = error_result(ERR_RECEIVER);
                        got = 1'b1;
                        drop_rest(b);
                    end else if (b <= MIN_LEN) begin
                        r          = error_result(ERR_LENGTH);
                        got        = 1'b1;
                        scan_state = HUNTING;
                    end
                end else if (cur_length != V1_LEN) begin
                    // wrong length is only reported once the declared length is reached
                    if (frame_pos >= cur_length) begin
                        r          = error_result(ERR_LENGTH);
                        got        = 1'b1;
                        scan_state = HUNTING;
                    end
                end else begin
                    case (frame_pos)
                        8'd5: cur_command = b;
                        8'd6: cur_value = {b, 8'h00};
                        8'd7: cur_value[7:0] = b;
                        8'd8: crc_low_byte = b;
                        default: begin
                            rx         = {b, crc_low_byte};
                            r          = (rx == crc_sum) ? ok_result(rx, V1_LEN)
                                                         : error_result(ERR_CHECK);
                            got        = 1'b1;
                            scan_state = HUNTING;
                        end
                    endcase
                end
                if (frame_pos <= 8'd6)
                    parity_sum ^= b;
                if (frame_pos <= 8'd7)
                    crc_sum = crc16_ccitt(crc_sum, b);
            end
        endcase
        if (last) begin
            if (!got && scan_state == IN_FRAME) begin
                r   = error_result(ERR_SHORT);
                got = 1'b1;
            end
            scan_state = HUNTING;
            skip_left  = '0;
            frame_pos  = '0;
        end else if (scan_state == HUNTING) begin
            frame_pos = '0;
        end
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatch_count++;
        end
    endfunction

    // Both channels are sampled at the rising edge. The result side is handled first:
    // a word accepted at this edge cannot have its result out before the next one.
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        logic          due;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_frames.size() == 0) begin
                    $error("result with none pending: error_code %0d", o_error_code);
                    mismatch_count++;
                end else begin
                    want = pending_frames.pop_front();
                    check_field("error_code",       16'(want.code),     16'(o_error_code));
                    check_field("sender_address",   16'(want.sender),
                                16'(o_sender_address));
                    check_field("receiver_address", 16'(want.receiver),
                                16'(o_receiver_address));
                    check_field("reply_flag",       16'(want.reply),    16'(o_reply_flag));
                    check_field("frame_version",    16'(want.version),
                                16'(o_frame_version));
                    check_field("command_char",     16'(want.command),
                                16'(o_command_char));
                    check_field("value_word",       want.value,         o_value_word);
                    check_field("decimal_value",    16'(want.decimal),
                                16'(o_decimal_value));
                    check_field("received_check",   want.check,         o_received_check);
                    check_field("frame_length",     16'(want.length),
                                16'(o_frame_length));
                end
            end
            if (i_valid && !o_stall) begin
                // the predictor always runs so its state tracks the stream; typed rows
                // replace its result with the code known by inspection
                deframe_byte(i_data_byte, i_end_of_buffer, due, want);
                if (row_typed)
                    queue_result(error_result(row_code));
                else if (due)
                    queue_result(want);
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- clock, stall, watchdog

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side. A requested hold-off is counted down here at each falling edge,
    // while the sender keeps offering words; otherwise stall at the phase's rate.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_left > 0) begin
                i_stall <= 1'b1;
                long_hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("testbench NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one word from the falling edge, with random sender gaps, and hold it until taken.
    task automatic send_word(input logic [7:0] b, input logic last,
                             input logic typed, input logic [2:0] code);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_buffer <= last;
        row_typed       <= typed;
        row_code        <= code;
        do
            @(posedge i_clk);
        while (o_stall);
        words_sent++;
    endtask

    // Sender pause: drop valid and wait until every owed result has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
    endtask

    // One random burst. Mostly well-formed v0 / v1 frames with random content, some of them
    // corrupted; the rest bad receiver, bad version, bad length, noise and junk. A burst may
    // be cut short by end of buffer.
    task automatic send_random_burst();
        logic [7:0]  frame_bytes[$];
        logic [7:0]  rcv;
        logic [7:0]  flags;
        logic [7:0]  len;
        logic [7:0]  cmd;
        logic [7:0]  parity;
        logic [15:0] crc;
        int          pick;
        int          declared;
        int          cut;
        int          i;
        pick  = $urandom_range(0, 99);
        rcv   = 8'($urandom_range(0, 127));
        flags = {7'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
        len   = V1_LEN;
        case ($urandom_range(0, 5))
            0:       cmd = CMD_HUMID;
            1:       cmd = CMD_TEMP;
            2:       cmd = CMD_SET;
            default: cmd = 8'($urandom_range(0, 255));
        endcase
        if (pick < 8) begin
            // noise only: zero or top half
            repeat ($urandom_range(1, 4))
                frame_bytes = {frame_bytes, ($urandom_range(0, 1) ? 8'h00
                                             : 8'($urandom_range(128, 255)))};
        end else if (pick < 14) begin
            repeat ($urandom_range(1, 12))
                frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
        end else begin
            if (pick < 22) begin
                rcv = 8'($urandom_range(128, 255));
            end else if (pick < 28) begin
                flags[7:1] = 7'($urandom_range(2, 127));
            end else if (pick < 36) begin
                flags[7:1] = VER_CRC;
                // mostly short lengths; now and then anything up to 255
                do
                    len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 20));
                while (len == V1_LEN);
            end
            frame_bytes = {frame_bytes, 8'($urandom_range(1, 127))};
            frame_bytes = {frame_bytes, rcv};
            frame_bytes = {frame_bytes, flags};
            if (flags[7:1] == VER_CRC)
                frame_bytes = {frame_bytes, len};
            frame_bytes = {frame_bytes, cmd};
            frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            if (flags[7:1] == VER_PARITY) begin
                parity = 8'h00;
                foreach (frame_bytes[k])
                    parity ^= frame_bytes[k];
                frame_bytes = {frame_bytes, parity};
            end else if (flags[7:1] == VER_CRC) begin
                crc = CRC_INIT;
                foreach (frame_bytes[k])
                    crc = crc16_ccitt(crc, frame_bytes[k]);
                frame_bytes = {frame_bytes, crc[7:0]};
                frame_bytes = {frame_bytes, crc[15:8]};
            end
            // trim or pad to the declared length; short v1 lengths stop at the length byte
            declared = (flags[7:1] == VER_CRC) ? int'(len) : int'(V0_LEN);
            while (frame_bytes.size() > ((declared > 4) ? declared : 4))
                void'(frame_bytes.pop_back());
            while (frame_bytes.size() < declared)
                frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            if (pick >= 36 && $urandom_range(0, 6) == 0) begin
                i = $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[i] = frame_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(0, frame_bytes.size() - 1);
        else if ($urandom_range(0, 29) == 0)
            cut = frame_bytes.size() - 1;
        else
            cut = -1;
        for (i = 0; i < frame_bytes.size(); i++) begin
            send_word(frame_bytes[i], i == cut, 1'b0, ERR_OK);
            if (i == cut)
                break;
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin : main
        int ph;
        int target;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = 8'h00;
        i_end_of_buffer = 1'b0;
        row_typed       = 1'b0;
        row_code        = ERR_OK;
        reset_scanner();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, no idling on either side
        for (ph = 0; ph < N_DIRECTED; ph++)
            send_word(directed_rows[ph].data, directed_rows[ph].last,
                      directed_rows[ph].typed, directed_rows[ph].code);
        wait_drained();

        // random phases: none, sender gaps, receiver stalls, both; each ends with a drain
        for (ph = 0; ph < 4; ph++) begin
            sender_idle_pct = sender_idle_by_phase[ph];
            stall_pct       = stall_by_phase[ph];
            // back the block up once: long receiver hold while words keep coming
            if (ph == 2)
                long_hold_left = HOLD_CYCLES;
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_random_burst();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/sfd_pkg.sv
rtl/core/sfd_crc_step.sv
rtl/core/serial_frame_deframer_checker_top.sv
rtl/core/sfd_checker.sv
bench/testbench.sv
